// File: rtl/mft_pkg.sv
// shared types and constants of the multi-turn motor angle tracker
package mft_pkg;

  // configuration register indexes
  localparam int unsigned CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] CFG_GROUP_A_BASE = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_GROUP_B_BASE = 2'd1;

  // reset values of the base identifiers
  localparam logic [10:0] GROUP_A_BASE_RST = 11'd513;
  localparam logic [10:0] GROUP_B_BASE_RST = 11'd517;

  // first slot of group b
  localparam logic [2:0] GROUP_B_FIRST_SLOT = 3'd4;

  // encoder arithmetic
  localparam logic signed [16:0] HALF_TURN = 17'sd4096;
  localparam int unsigned TurnShift = 13;  // 8191 = 2^13 - 1
  localparam logic signed [15:0] TURN_MIN = 16'sh8000;
  localparam logic signed [15:0] TURN_MAX = 16'sh7FFF;

  // depth of the queue between decode and update
  localparam int unsigned QUEUE_DEPTH = 2;

  // one decoded feedback word
  typedef struct packed {
    logic [2:0]         slot;
    logic               group_b;
    logic [15:0]        angle;
    logic signed [15:0] speed;
    logic signed [15:0] current;
    logic [7:0]         temp;
  } mft_item_t;

  // queue status toward its neighbors
  typedef struct packed {
    logic full;
    logic empty;
  } mft_queue_status_t;

endpackage

// File: rtl/mft_front.sv
// front end: matches the frame id to a slot and unpacks the data bytes
module mft_front import mft_pkg::*; #(
  parameter int unsigned GROUP_SIZE = 4,
  parameter int unsigned SLOT_COUNT = 8
) (
  input  logic [10:0] group_a_base_i,
  input  logic [10:0] group_b_base_i,
  input  logic [10:0] frame_id_i,
  input  logic [7:0]  angle_high_i,
  input  logic [7:0]  angle_low_i,
  input  logic [7:0]  speed_high_i,
  input  logic [7:0]  speed_low_i,
  input  logic [7:0]  current_high_i,
  input  logic [7:0]  current_low_i,
  input  logic [7:0]  temperature_byte_i,
  output logic        mapped_o,
  output mft_item_t   item_o
);

  logic [11:0] diff_a;
  logic [11:0] diff_b;
  logic        hit_a;
  logic        hit_b;
  logic [2:0]  slot;

  // offset of the id from each group base
  assign diff_a = {1'b0, frame_id_i} - {1'b0, group_a_base_i};
  assign diff_b = {1'b0, frame_id_i} - {1'b0, group_b_base_i};
  assign hit_a  = !diff_a[11] && (diff_a[10:0] < 11'(GROUP_SIZE));
  assign hit_b  = !diff_b[11] && (diff_b[10:0] < 11'(GROUP_SIZE));

  // group a wins when both match
  always_comb begin
    if (hit_a) begin
      slot = {1'b0, diff_a[1:0]};
    end else begin
      slot = {1'b0, diff_b[1:0]} + GROUP_B_FIRST_SLOT;
    end
  end

  assign mapped_o = (hit_a || hit_b) && ({1'b0, slot} < 4'(SLOT_COUNT));

  // unpack big-endian fields
  assign item_o.slot    = slot;
  assign item_o.group_b = !hit_a;
  assign item_o.angle   = {angle_high_i, angle_low_i};
  assign item_o.speed   = $signed({speed_high_i, speed_low_i});
  assign item_o.current = $signed({current_high_i, current_low_i});
  assign item_o.temp    = temperature_byte_i;

endmodule

// File: rtl/mft_queue.sv
// short fifo of decoded words between front and back end
module mft_queue import mft_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  mft_item_t         push_item_i,
  input  logic              pop_i,
  output mft_item_t         head_o,
  output mft_queue_status_t status_o
);

  localparam int unsigned PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);

  mft_item_t       mem_q [QUEUE_DEPTH];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;

  assign status_o.full  = (count_q == CntW'(QUEUE_DEPTH));
  assign status_o.empty = (count_q == '0);
  assign head_o         = mem_q[rd_ptr_q];

  // pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

  // no push into a full queue, no pop from an empty one
  assert property (@(posedge clk_i) disable iff (!rst_ni) !(push_i && status_o.full))
    else $error("push into full queue");
  assert property (@(posedge clk_i) disable iff (!rst_ni) !(pop_i && status_o.empty))
    else $error("pop from empty queue");

endmodule

// File: rtl/mft_back.sv
// back end: per-slot angle unwrap and the registered result word
module mft_back import mft_pkg::*; #(
  parameter int unsigned SLOT_COUNT = 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               item_valid_i,
  input  mft_item_t          item_i,
  output logic               take_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [2:0]         motor_slot_o,
  output logic [15:0]        rotor_angle_o,
  output logic signed [15:0] rotor_speed_o,
  output logic signed [15:0] torque_current_o,
  output logic [7:0]         temperature_o,
  output logic signed [29:0] total_angle_o,
  output logic signed [15:0] turn_count_o
);

  localparam int unsigned IdxW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

  logic [15:0]          prev_q  [SLOT_COUNT];
  logic signed [15:0]   round_q [SLOT_COUNT];
  logic [SLOT_COUNT-1:0] seen_q;

  logic                 out_valid_q;
  logic [IdxW-1:0]      idx;
  logic [15:0]          prev;
  logic signed [15:0]   rounds;
  logic signed [15:0]   rounds_d;
  logic signed [29:0]   rounds_w;
  logic signed [29:0]   total_d;
  logic signed [16:0]   delta;
  logic                 count_now;

  // take the head word when the result register is free or draining
  assign take_o      = item_valid_i && (!out_valid_q || out_ready_i);
  assign out_valid_o = out_valid_q;

  // read the slot state
  assign idx    = item_i.slot[IdxW-1:0];
  assign prev   = prev_q[idx];
  assign rounds = round_q[idx];

  // total angle from the round count held before this word
  assign rounds_w = {{14{rounds[15]}}, rounds};
  assign total_d  = $signed({14'b0, item_i.angle}) + (rounds_w <<< TurnShift) - rounds_w;

  // unwrap with saturation; first group b word only marks the slot
  assign delta     = $signed({1'b0, item_i.angle}) - $signed({1'b0, prev});
  assign count_now = !(item_i.group_b && !seen_q[idx]);

  always_comb begin
    rounds_d = rounds;
    if (count_now) begin
      if (delta > HALF_TURN) begin
        if (rounds != TURN_MIN) begin
          rounds_d = rounds - 16'sd1;
        end
      end else if (delta < -HALF_TURN) begin
        if (rounds != TURN_MAX) begin
          rounds_d = rounds + 16'sd1;
        end
      end
    end
  end

  // slot store
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < SLOT_COUNT; i++) begin
        prev_q[i]  <= '0;
        round_q[i] <= '0;
      end
      seen_q <= '0;
    end else if (take_o) begin
      prev_q[idx]  <= item_i.angle;
      round_q[idx] <= rounds_d;
      if (item_i.group_b) begin
        seen_q[idx] <= 1'b1;
      end
    end
  end

  // result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (take_o) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (take_o) begin
      motor_slot_o     <= item_i.slot;
      rotor_angle_o    <= item_i.angle;
      rotor_speed_o    <= item_i.speed;
      torque_current_o <= item_i.current;
      temperature_o    <= item_i.temp;
      total_angle_o    <= total_d;
      turn_count_o     <= rounds_d;
    end
  end

  // a taken word always shows up as a result next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni) take_o |=> out_valid_q)
    else $error("taken word produced no result");
  // group a words never touch the seen flags
  assert property (@(posedge clk_i) disable iff (!rst_ni)
      (take_o && !item_i.group_b) |=> (seen_q == $past(seen_q)))
    else $error("group a word changed a seen flag");

endmodule

// File: rtl/motor_feedback_multiturn_tracker_top.sv
// top level of the multi-turn motor angle tracker
// Takes one motor feedback frame per word and, for ids that map to a slot of
// group a or group b, returns one result word with the unpacked fields, the
// total angle and the updated turn count; unmapped ids are consumed with no
// result. Throughput is one word per cycle while out_ready_i is high; the back
// end reads, unwraps and writes the slot store as it takes a word, and the
// result register loads when free, once the word heads the two-word queue.
// The queue lets input keep flowing while a result waits. Base ids are written
// through the plain write port and must only change while the block is idle.
module motor_feedback_multiturn_tracker_top import mft_pkg::*; #(
  parameter int unsigned GROUP_SIZE = 4,
  parameter int unsigned SLOT_COUNT = 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [10:0]        cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [10:0]        frame_id_i,
  input  logic [7:0]         angle_high_i,
  input  logic [7:0]         angle_low_i,
  input  logic [7:0]         speed_high_i,
  input  logic [7:0]         speed_low_i,
  input  logic [7:0]         current_high_i,
  input  logic [7:0]         current_low_i,
  input  logic [7:0]         temperature_byte_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [2:0]         motor_slot_o,
  output logic [15:0]        rotor_angle_o,
  output logic signed [15:0] rotor_speed_o,
  output logic signed [15:0] torque_current_o,
  output logic [7:0]         temperature_o,
  output logic signed [29:0] total_angle_o,
  output logic signed [15:0] turn_count_o
);

  logic [10:0]       group_a_base_q;
  logic [10:0]       group_b_base_q;
  logic              mapped;
  mft_item_t         front_item;
  mft_item_t         head_item;
  mft_queue_status_t q_status;
  logic              push;
  logic              take;

  // base id registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      group_a_base_q <= GROUP_A_BASE_RST;
      group_b_base_q <= GROUP_B_BASE_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_GROUP_A_BASE: group_a_base_q <= cfg_wdata_i;
        CFG_GROUP_B_BASE: group_b_base_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  mft_front #(
    .GROUP_SIZE(GROUP_SIZE),
    .SLOT_COUNT(SLOT_COUNT)
  ) u_front (
    .group_a_base_i     (group_a_base_q),
    .group_b_base_i     (group_b_base_q),
    .frame_id_i         (frame_id_i),
    .angle_high_i       (angle_high_i),
    .angle_low_i        (angle_low_i),
    .speed_high_i       (speed_high_i),
    .speed_low_i        (speed_low_i),
    .current_high_i     (current_high_i),
    .current_low_i      (current_low_i),
    .temperature_byte_i (temperature_byte_i),
    .mapped_o           (mapped),
    .item_o             (front_item)
  );

  // accept while the queue has room; only mapped words are queued
  assign in_ready_o = !q_status.full;
  assign push       = in_valid_i && in_ready_o && mapped;

  mft_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_item_i (front_item),
    .pop_i       (take),
    .head_o      (head_item),
    .status_o    (q_status)
  );

  mft_back #(
    .SLOT_COUNT(SLOT_COUNT)
  ) u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .item_valid_i     (!q_status.empty),
    .item_i           (head_item),
    .take_o           (take),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .motor_slot_o     (motor_slot_o),
    .rotor_angle_o    (rotor_angle_o),
    .rotor_speed_o    (rotor_speed_o),
    .torque_current_o (torque_current_o),
    .temperature_o    (temperature_o),
    .total_angle_o    (total_angle_o),
    .turn_count_o     (turn_count_o)
  );

endmodule
